[sv/las_pkg.sv]
`default_nettype none

package las_pkg;

  // fixed field and register widths
  localparam int SCORE_BITS  = 28;
  localparam int MASK_BITS   = 16;
  localparam int OFFSET_BITS = 4;
  localparam int APB_BITS    = 32;
  localparam int ADDR_BITS   = 3;

  // score saturation limits
  localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  // register word indexes (paddr[2])
  localparam logic REG_COUNT_MODE = 1'b0;
  localparam logic REG_BIT_MASK   = 1'b1;

  // reset values of the registers
  localparam logic                 COUNT_MODE_RST = 1'b0;
  localparam logic [MASK_BITS-1:0] BIT_MASK_RST   = 16'h0001;

  // sequencer states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_SCAN,
    ST_EMIT
  } las_state_t;

  // control shared by all lag cells
  typedef struct packed {
    logic                 add_en;
    logic                 count_mode;
    logic [MASK_BITS-1:0] bit_mask;
    logic                 shift;
  } las_ctrl_t;

endpackage

`default_nettype wire

[sv/las_lag_cell.sv]
`default_nettype none

module las_lag_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire las_pkg::las_ctrl_t                     ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0]          tap_sample,
  input  wire logic                                   tap_valid,
  input  wire logic signed [las_pkg::SCORE_BITS-1:0]  score_in,
  output logic signed [las_pkg::SCORE_BITS-1:0]       score
);

  localparam int AW = ((SAMPLE_BITS > las_pkg::SCORE_BITS) ?
                       SAMPLE_BITS : las_pkg::SCORE_BITS) + 1;
  localparam int MW = (SAMPLE_BITS > las_pkg::MASK_BITS) ?
                      SAMPLE_BITS : las_pkg::MASK_BITS;
  localparam logic signed [AW-1:0] HI = AW'(las_pkg::SCORE_MAX);
  localparam logic signed [AW-1:0] LO = AW'(las_pkg::SCORE_MIN);

  logic [MW-1:0]                          masked;
  logic signed [AW-1:0]                   contrib;
  logic signed [AW-1:0]                   sum;
  logic signed [las_pkg::SCORE_BITS-1:0]  score_next;

  // contribution of the tapped sample, then saturating add
  always_comb begin
    masked = MW'($unsigned(tap_sample)) & MW'(ctrl.bit_mask);
    if (ctrl.count_mode) begin
      contrib = {{(AW-1){1'b0}}, |masked};
    end else begin
      contrib = AW'(tap_sample);
    end
    sum = AW'(score) + contrib;
    priority if (sum > HI) begin
      score_next = las_pkg::SCORE_MAX;
    end else if (sum < LO) begin
      score_next = las_pkg::SCORE_MIN;
    end else begin
      score_next = las_pkg::SCORE_BITS'(sum);
    end
  end

  // score register: shifts toward lag zero during the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      score <= '0;
    end else if (ctrl.shift) begin
      score <= score_in;
    end else if (ctrl.add_en && tap_valid) begin
      score <= score_next;
    end
  end

endmodule

`default_nettype wire

[sv/lag_alignment_search.sv]
// channel   direction  handshake          payload
// in        input      in_valid/in_stall    sample_value, onset_flag, is_last
// out       output     out_valid/out_stall  best_offset
// apb       input      psel/penable/pready  paddr, pwdata, prdata (count_mode, bit_mask)
//
// one item per cycle inside a run; each lag cell adds its valid tap when the delayed onset flag is set
// after the last item in_stall is high through a flush of the run tail, a scan
// through the chain of 2*LAG_RADIUS+1 cells and one emit
// the emit waits longer while the previous result is still stalled at out
// synchronous reset clears window valid bits, scores, state and registers
// a result waits in the output register while the next run streams in

`default_nettype none

module lag_alignment_search #(
  parameter int LAG_RADIUS  = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // item input
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample_value,
  input  wire logic                                 onset_flag,
  input  wire logic                                 is_last,
  // result output
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [las_pkg::OFFSET_BITS-1:0]    best_offset,
  // register port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [las_pkg::ADDR_BITS-1:0]        paddr,
  input  wire logic [las_pkg::APB_BITS-1:0]         pwdata,
  output logic [las_pkg::APB_BITS-1:0]              prdata,
  output logic                                      pready
);

  localparam int WIN  = 2 * LAG_RADIUS + 1;
  localparam int LINE = 3 * LAG_RADIUS + 1;
  localparam int CW   = $clog2(WIN);

  las_pkg::las_state_t state, state_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic                flush_shift, flush_clear, scan_shift, emit_load;

  logic                                count_mode;
  logic [las_pkg::MASK_BITS-1:0]       bit_mask;

  logic signed [SAMPLE_BITS-1:0]       win_smp [0:LINE-1];
  logic [LINE-1:0]                     win_vld;
  logic [LAG_RADIUS:0]                 onset_line;
  logic                                run_score;
  logic                                in_acc;
  logic                                cfg_wr;

  las_pkg::las_ctrl_t                  ctrl;
  logic signed [las_pkg::SCORE_BITS-1:0] cell_score [0:WIN];

  logic signed [las_pkg::SCORE_BITS-1:0] best_val;
  logic [CW-1:0]                       best_idx;
  logic signed [CW:0]                  off_full;

  assign in_acc = in_valid && !in_stall;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode <= las_pkg::COUNT_MODE_RST;
      bit_mask   <= las_pkg::BIT_MASK_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        las_pkg::REG_COUNT_MODE: count_mode <= pwdata[0];
        las_pkg::REG_BIT_MASK:   bit_mask   <= pwdata[las_pkg::MASK_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      las_pkg::REG_COUNT_MODE: prdata = las_pkg::APB_BITS'(count_mode);
      las_pkg::REG_BIT_MASK:   prdata = las_pkg::APB_BITS'(bit_mask);
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= las_pkg::ST_RUN;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and control
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    flush_shift = 1'b0;
    flush_clear = 1'b0;
    scan_shift  = 1'b0;
    emit_load   = 1'b0;
    in_stall    = 1'b1;
    unique case (state)
      las_pkg::ST_RUN: begin
        in_stall = 1'b0;
        if (in_valid && is_last) begin
          state_next = las_pkg::ST_FLUSH;
          cnt_next   = '0;
        end
      end
      las_pkg::ST_FLUSH: begin
        if (cnt == CW'(LAG_RADIUS)) begin
          flush_clear = 1'b1;
          state_next  = las_pkg::ST_SCAN;
          cnt_next    = '0;
        end else begin
          flush_shift = 1'b1;
          cnt_next    = cnt + 1'b1;
        end
      end
      las_pkg::ST_SCAN: begin
        scan_shift = 1'b1;
        if (cnt == CW'(2 * LAG_RADIUS)) begin
          state_next = las_pkg::ST_EMIT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      las_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit_load  = 1'b1;
          state_next = las_pkg::ST_RUN;
        end
      end
    endcase
  end

  // window valid bits: shift up in a run, realign on the last item,
  // shift down while flushing the tail of the run
  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= '0;
    end else if (in_acc && !is_last) begin
      win_vld[0] <= 1'b1;
      for (int j = 1; j < WIN; j++) begin
        win_vld[j] <= win_vld[j-1];
      end
      for (int j = WIN; j < LINE; j++) begin
        win_vld[j] <= 1'b0;
      end
    end else if (in_acc) begin
      for (int j = 0; j < LAG_RADIUS; j++) begin
        win_vld[j] <= 1'b0;
      end
      win_vld[LAG_RADIUS] <= 1'b1;
      for (int j = LAG_RADIUS + 1; j < LINE; j++) begin
        win_vld[j] <= win_vld[j-LAG_RADIUS-1];
      end
    end else if (flush_shift) begin
      for (int j = 0; j < LINE - 1; j++) begin
        win_vld[j] <= win_vld[j+1];
      end
      win_vld[LINE-1] <= 1'b0;
    end else if (flush_clear) begin
      win_vld <= '0;
    end
  end

  // window samples, same moves as the valid bits
  always_ff @(posedge clk) begin
    if (in_acc && !is_last) begin
      win_smp[0] <= sample_value;
      for (int j = 1; j < WIN; j++) begin
        win_smp[j] <= win_smp[j-1];
      end
    end else if (in_acc) begin
      win_smp[LAG_RADIUS] <= sample_value;
      for (int j = LAG_RADIUS + 1; j < LINE; j++) begin
        win_smp[j] <= win_smp[j-LAG_RADIUS-1];
      end
    end else if (flush_shift) begin
      for (int j = 0; j < LINE - 1; j++) begin
        win_smp[j] <= win_smp[j+1];
      end
    end
  end

  // onset delay line; reversed on the last item so the flush reads
  // the newest position first
  always_ff @(posedge clk) begin
    if (rst) begin
      onset_line <= '0;
      run_score  <= 1'b0;
    end else begin
      run_score <= in_acc && !is_last;
      if (in_acc && !is_last) begin
        onset_line <= {onset_line[LAG_RADIUS-1:0], onset_flag};
      end else if (in_acc) begin
        onset_line[LAG_RADIUS] <= onset_flag;
        for (int k = 0; k < LAG_RADIUS; k++) begin
          onset_line[k] <= onset_line[LAG_RADIUS-k-1];
        end
      end else if (flush_shift) begin
        onset_line <= {onset_line[LAG_RADIUS-1:0], 1'b0};
      end else if (flush_clear) begin
        onset_line <= '0;
      end
    end
  end

  // control broadcast to the cell chain
  always_comb begin
    ctrl.add_en     = (run_score || (state == las_pkg::ST_FLUSH)) && onset_line[LAG_RADIUS];
    ctrl.count_mode = count_mode;
    ctrl.bit_mask   = bit_mask;
    ctrl.shift      = scan_shift;
  end

  // one cell per lag, each tapping its own window slot
  assign cell_score[WIN] = '0;

  for (genvar L = 0; L < WIN; L++) begin : g_lag
    las_lag_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .tap_sample (win_smp[2*LAG_RADIUS-L]),
      .tap_valid  (win_vld[2*LAG_RADIUS-L]),
      .score_in   (cell_score[L+1]),
      .score      (cell_score[L])
    );
  end

  // running maximum over scores leaving the chain, earliest lag wins ties
  always_ff @(posedge clk) begin
    if (scan_shift) begin
      if (cnt == '0 || cell_score[0] > best_val) begin
        best_val <= cell_score[0];
        best_idx <= cnt;
      end
    end
  end

  assign off_full = $signed({1'b0, best_idx}) - $signed((CW+1)'(LAG_RADIUS));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      best_offset <= las_pkg::OFFSET_BITS'(off_full);
    end
  end

endmodule

`default_nettype wire

[sv/las_checker.sv]
`default_nettype none

module las_checker #(
  parameter int LAG_RADIUS = 5
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                is_last,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [las_pkg::OFFSET_BITS-1:0] best_offset
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(best_offset))
    else $error("stalled result changed");

  // offset stays within the lag range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (best_offset >= -LAG_RADIUS) && (best_offset <= LAG_RADIUS))
    else $error("offset out of lag range");

  // end of a run blocks input while the chain drains
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && is_last |=> in_stall)
    else $error("input taken right after end of run");

  // a new result only appears after input was held off
  a_rose_after_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without end of run");

endmodule

bind lag_alignment_search las_checker #(
  .LAG_RADIUS (LAG_RADIUS)
) u_las_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .is_last     (is_last),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .best_offset (best_offset)
);

`default_nettype wire

[tb/sv/lag_search_check_pkg.sv]
package lag_search_check_pkg;

  localparam int LAG_RADIUS = 5;
  localparam int LAG_TAPS   = 2 * LAG_RADIUS + 1;
  localparam int SAMPLE_W   = 16;

  // count_mode register values
  localparam bit MODE_WEIGHTED = 1'b0;
  localparam bit MODE_COUNT    = 1'b1;

  localparam int MAX_REPORTS = 10;

  // tracks the lag scores of the open run and holds the offsets still owed by the block
  class lag_offset_scoreboard;
    logic [SAMPLE_W-1:0]                          window    [LAG_TAPS];
    bit                                           window_ok [LAG_TAPS];
    bit                                           onset_dly [LAG_RADIUS+1];
    logic signed [las_pkg::SCORE_BITS-1:0]        score     [LAG_TAPS];
    bit                                           count_mode;
    logic [las_pkg::MASK_BITS-1:0]                bit_mask;
    logic signed [las_pkg::OFFSET_BITS-1:0]       offset_q  [$];
    int                                           mismatches;

    function new();
      count_mode = las_pkg::COUNT_MODE_RST;
      bit_mask   = las_pkg::BIT_MASK_RST;
      mismatches = 0;
      clear_run();
    endfunction

    function void set_config(bit mode, logic [las_pkg::MASK_BITS-1:0] mask);
      count_mode = mode;
      bit_mask   = mask;
    endfunction

    function int pending();
      return offset_q.size();
    endfunction

    function void report(string what, int expected_val, int actual_val);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("mismatch: %s expected %0d actual %0d", what, expected_val, actual_val);
      end
    endfunction

    function void clear_run();
      for (int k = 0; k < LAG_TAPS; k++) begin
        window[k]    = '0;
        window_ok[k] = 1'b0;
        score[k]     = '0;
      end
      for (int k = 0; k <= LAG_RADIUS; k++) begin
        onset_dly[k] = 1'b0;
      end
    endfunction

    // saturating accumulate into one lag score
    function void add_to_score(int lag_idx, int amount);
      longint total;
      total = longint'(score[lag_idx]) + amount;
      if (total > longint'(las_pkg::SCORE_MAX)) total = longint'(las_pkg::SCORE_MAX);
      if (total < longint'(las_pkg::SCORE_MIN)) total = longint'(las_pkg::SCORE_MIN);
      score[lag_idx] = las_pkg::SCORE_BITS'(total);
    endfunction

    // score the onset that lies back items behind the newest one
    function void score_position(int back);
      int                         tap;
      logic signed [SAMPLE_W-1:0] value;
      if (!onset_dly[back]) return;
      for (int d = -LAG_RADIUS; d <= LAG_RADIUS; d++) begin
        tap = back - d;
        if (tap < 0 || tap >= LAG_TAPS) continue;
        if (!window_ok[tap]) continue;
        value = window[tap];
        if (count_mode == MODE_COUNT) begin
          add_to_score(d + LAG_RADIUS, ((window[tap] & bit_mask) != '0) ? 1 : 0);
        end else begin
          add_to_score(d + LAG_RADIUS, value);
        end
      end
    endfunction

    // accepted input transaction: shift it in, score, and on the last item predict the offset
    function void note_item(logic [SAMPLE_W-1:0] sample, bit onset, bit last);
      int best;
      for (int k = LAG_TAPS - 1; k > 0; k--) begin
        window[k]    = window[k-1];
        window_ok[k] = window_ok[k-1];
      end
      window[0]    = sample;
      window_ok[0] = 1'b1;
      for (int k = LAG_RADIUS; k > 0; k--) begin
        onset_dly[k] = onset_dly[k-1];
      end
      onset_dly[0] = onset;

      if (!last) begin
        score_position(LAG_RADIUS);
        return;
      end

      // end of run: the trailing onsets see no neighbours past the end
      for (int c = 0; c <= LAG_RADIUS; c++) begin
        score_position(c);
      end
      // argmax, most negative lag wins ties
      best = 0;
      for (int k = 1; k < LAG_TAPS; k++) begin
        if (score[k] > score[best]) best = k;
      end
      offset_q.push_back(las_pkg::OFFSET_BITS'(best - LAG_RADIUS));
      clear_run();
    endfunction

    // accepted output transaction against the oldest predicted offset
    function void check_result(logic signed [las_pkg::OFFSET_BITS-1:0] actual);
      logic signed [las_pkg::OFFSET_BITS-1:0] predicted;
      if (offset_q.size() == 0) begin
        report("best_offset with no run pending", 0, actual);
        return;
      end
      predicted = offset_q.pop_front();
      if (actual !== predicted) begin
        report("best_offset", predicted, actual);
      end
    endfunction
  endclass

endpackage

[tb/sv/lag_alignment_search_tb.sv]
module lag_alignment_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lag_search_check_pkg::*;

  localparam int          SEGMENTS     = 6;
  localparam int          SEG_ITEMS    = 270;
  localparam int          HOLD_CYCLES  = 400;
  // flush, scan and emit after the last item, plus margin
  localparam int          DRAIN_CYCLES = 3 * LAG_RADIUS + 3 + 20;
  localparam int unsigned LIMIT_CYCLES = 400000;

  bit   clk;
  logic rst;

  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [SAMPLE_W-1:0]             sample_value;
  logic                                   onset_flag;
  logic                                   is_last;
  logic                                   out_valid;
  logic                                   out_stall;
  logic signed [las_pkg::OFFSET_BITS-1:0] best_offset;
  logic                                   psel;
  logic                                   penable;
  logic                                   pwrite;
  logic [las_pkg::ADDR_BITS-1:0]          paddr;
  logic [las_pkg::APB_BITS-1:0]           pwdata;
  logic [las_pkg::APB_BITS-1:0]           prdata;
  logic                                   pready;

  lag_offset_scoreboard sb;

  int          send_gap_pct;
  int          recv_stall_pct;
  int          hold_requests;
  int          holds_served;
  int          hold_left;
  int unsigned cycle_count;

  // per-segment register settings
  bit                            seg_mode [SEGMENTS] = '{MODE_WEIGHTED, MODE_COUNT, MODE_COUNT,
                                                         MODE_COUNT, MODE_WEIGHTED, MODE_COUNT};
  logic [las_pkg::MASK_BITS-1:0] seg_mask [SEGMENTS] = '{16'hFFFF, 16'h0001, 16'hFFFF,
                                                         16'h0000, 16'h0000, 16'h0001};

  lag_alignment_search dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .onset_flag   (onset_flag),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .best_offset  (best_offset),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(best_offset);
      if (in_valid && !in_stall) sb.note_item(sample_value, onset_flag, is_last);
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // one register port access, entered and left at a falling edge
  task reg_access(input logic idx, input bit write, input logic [las_pkg::APB_BITS-1:0] wdata,
                  output logic [las_pkg::APB_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // return to idle before the next access
    @(negedge clk);
  endtask

  // read both registers back and compare
  task check_registers();
    logic [las_pkg::APB_BITS-1:0] rdata;
    reg_access(las_pkg::REG_COUNT_MODE, 1'b0, '0, rdata);
    if (rdata !== las_pkg::APB_BITS'(sb.count_mode)) begin
      sb.report("count_mode readback", sb.count_mode, rdata);
    end
    reg_access(las_pkg::REG_BIT_MASK, 1'b0, '0, rdata);
    if (rdata !== las_pkg::APB_BITS'(sb.bit_mask)) begin
      sb.report("bit_mask readback", sb.bit_mask, rdata);
    end
  endtask

  task set_registers(input bit mode, input logic [las_pkg::MASK_BITS-1:0] mask);
    logic [las_pkg::APB_BITS-1:0] rdata;
    reg_access(las_pkg::REG_COUNT_MODE, 1'b1, las_pkg::APB_BITS'(mode), rdata);
    reg_access(las_pkg::REG_BIT_MASK, 1'b1, las_pkg::APB_BITS'(mask), rdata);
    sb.set_config(mode, mask);
    check_registers();
  endtask

  // offer one item until accepted; valid stays high on return
  task send_item(input logic [SAMPLE_W-1:0] sample, input bit onset, input bit last);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= sample;
    onset_flag   <= onset;
    is_last      <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering until every predicted offset has come out, then let the block settle
  task settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function logic [SAMPLE_W-1:0] pick_sample(int kind);
    logic [SAMPLE_W-1:0] s;
    case (kind)
      0: s = SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: s = 16'h8000;
          1: s = 16'h7FFF;
          2: s = 16'hFFFF;
          3: s = 16'h0001;
          default: s = 16'h0000;
        endcase
      end
      // small values make ties likely
      2: s = SAMPLE_W'($urandom_range(0, 3));
      3: s = '0;
      default: s = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
    endcase
    return s;
  endfunction

  // one complete run with random length, sample style and onset density
  task send_run(output int count);
    int len;
    int kind;
    int onset_pct;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(1, 12);
    else if (pick < 95) len = $urandom_range(13, 60);
    else len = $urandom_range(100, 300);
    kind = $urandom_range(0, 4);
    case ($urandom_range(0, 3))
      0: onset_pct = 0;
      1: onset_pct = 10;
      2: onset_pct = 50;
      default: onset_pct = 100;
    endcase
    for (int i = 0; i < len; i++) begin
      send_item(pick_sample(kind), ($urandom_range(0, 99) < onset_pct), (i == len - 1));
    end
    count = len;
  endtask

  initial begin
    int sent;
    int run_len;
    bit held;

    // known values from the start
    rst            = 1'b1;
    in_valid       = 1'b0;
    sample_value   = '0;
    onset_flag     = 1'b0;
    is_last        = 1'b0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    holds_served   = 0;
    hold_left      = 0;
    cycle_count    = 0;
    held           = 1'b0;
    seg_mask[5]    = las_pkg::MASK_BITS'($urandom_range(1, 16'hFFFE));
    sb = new();

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values of the registers
    check_registers();

    // one-item run with an onset: only lag zero scores
    send_item(16'h7FFF, 1'b1, 1'b1);
    // one-item run without onset: all scores zero
    send_item(16'h1234, 1'b0, 1'b1);
    // run shorter than the radius, negative extremes around the onset
    send_item(16'h8000, 1'b0, 1'b0);
    send_item(16'd100, 1'b1, 1'b0);
    send_item(16'h8000, 1'b0, 1'b1);
    // longer alternating run of extremes
    for (int i = 0; i < 12; i++) begin
      send_item((i % 2) ? 16'h7FFF : 16'h8000, (i % 3 == 0), (i == 11));
    end
    settle();

    // count mode on the sign bit
    set_registers(MODE_COUNT, 16'h8000);
    send_item(16'h8000, 1'b1, 1'b0);
    send_item(16'h0001, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'h7FFF, 1'b0, 1'b0);
    send_item(16'hFFFE, 1'b1, 1'b1);

    // random runs under changing settings and idle profiles
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      if (seg < 2) begin
        send_gap_pct   = 18;
        recv_stall_pct = 68;
      end else if (seg < 4) begin
        send_gap_pct   = 68;
        recv_stall_pct = 18;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      set_registers(seg_mode[seg], seg_mask[seg]);
      sent = 0;
      while (sent < SEG_ITEMS) begin
        send_run(run_len);
        sent += run_len;
        // long receiver hold-off while runs keep coming
        if (seg == 0 && !held && sent >= 100) begin
          hold_requests++;
          held = 1'b1;
        end
        if ($urandom_range(0, 29) == 0) settle();
      end
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
